// ===== hdl/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants for the keyed record table
// Field widths, status and mode codes, register map, controller states and
// the control bundle that drives the record store.
// ----------------------------------------------------------------------------
package krt_pkg;

  // Record and result field widths
  localparam int KEY_W    = 31;
  localparam int PHONE_W  = 31;
  localparam int NAME_W   = 64;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int CAP_W    = 7;
  localparam int CNT_W    = 7;

  // Stream payload widths (packed fields, padded to whole bytes)
  localparam int S_TDATA_W = 128;
  localparam int M_TDATA_W = 136;
  localparam int M_PAD_W   = M_TDATA_W - SLOT_W - KEY_W - PHONE_W - NAME_W;

  // Register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register map: index taken from the word address bit
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Default table depth
  localparam int TABLE_DEPTH_DEF = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND     = 3'd0,
    STATUS_NOT_FOUND = 3'd1,
    STATUS_ADDED     = 3'd2,
    STATUS_UPDATED   = 3'd3,
    STATUS_FULL      = 3'd4,
    STATUS_REMOVED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FETCH
  } state_e;

  // Store access strobes for one cycle
  typedef struct packed {
    logic key_rd;
    logic key_wr;
    logic data_rd;
    logic data_wr;
  } mem_ctl_t;

endpackage

// ===== hdl/keyed_record_table_core.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_core: fixed-capacity keyed record table
// Lookup, add-or-update and remove requests over a table of (key, phone,
// name tag) records; key zero marks an empty slot.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Contents
//  s_axis    in   tvalid/tready      tuser: mode; tdata: key, phone, name_tag
//  m_axis    out  tvalid/tready      tuser: status; tdata: slot, found_key,
//                                    found_phone, found_name
//  apb       in   psel/penable/pready register 0: capacity
//
//  A request is accepted, then the key memory scan reads one slot per cycle
//  over n = min(capacity, TABLE_DEPTH) slots and drains its last read before
//  the decision; a lookup or remove that hits then fetches the record. A
//  request with key zero or mode 3 skips the scan, and at capacity zero the
//  scan reads no slot.
//  After reset a clearing pass writes every key slot to zero, during which
//  no request is accepted; register writes are taken.
//  A new request is accepted while a result waits in the output register;
//  the controller stalls before its own result until that register frees.
//
module keyed_record_table_core #(
  parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [1:0] mode
  input  logic [krt_pkg::MODE_W-1:0]     s_axis_tuser,
  // [30:0] key, [61:31] phone, [125:62] name_tag, [127:126] zero
  input  logic [krt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] status
  output logic [krt_pkg::STATUS_W-1:0]   m_axis_tuser,
  // [5:0] slot, [36:6] found_key, [67:37] found_phone, [131:68] found_name,
  // [135:132] zero
  output logic [krt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [krt_pkg::APB_AW-1:0]     paddr,
  input  logic [krt_pkg::APB_DW-1:0]     pwdata,
  output logic [krt_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import krt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int NW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;

  // Register port
  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_q) : '0;

  // Effective slot count
  logic [NW-1:0] cap_ext;
  logic [NW-1:0] n_slots;

  assign cap_ext = NW'(cap_q);
  assign n_slots = (cap_ext < NW'(TABLE_DEPTH)) ? cap_ext : NW'(TABLE_DEPTH);

  // Controller state
  state_e            state_q, state_d;
  logic [NW-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              s_fire;
  logic              out_free;

  // Request registers
  mode_e             req_mode_q;
  logic [KEY_W-1:0]  req_key_q;
  logic [PHONE_W-1:0] req_phone_q;
  logic [NAME_W-1:0] req_name_q;
  logic              req_bad_q;

  // Scan tracking
  logic              rvld_q;
  logic [IW-1:0]     ridx_q;
  logic              hit_q;
  logic [IW-1:0]     hit_idx_q;
  logic              empty_q;
  logic [IW-1:0]     empty_idx_q;

  // Store interface
  mem_ctl_t          ctl;
  logic [IW-1:0]     addr;
  logic [KEY_W-1:0]  key_wr;
  logic [KEY_W-1:0]  key_rd;
  logic [PHONE_W-1:0] phone_rd;
  logic [NAME_W-1:0] name_rd;

  // Result selection
  logic              out_load;
  status_e           res_status;
  logic              res_touch;
  logic [IW-1:0]     res_slot;
  logic              use_rd;

  // Output register
  logic              m_valid_q;
  status_e           m_status_q;
  logic [SLOT_W-1:0] m_slot_q;
  logic [KEY_W-1:0]  m_key_q;
  logic [PHONE_W-1:0] m_phone_q;
  logic [NAME_W-1:0] m_name_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  krt_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IW          (IW)
  ) u_store (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .addr_i     (addr),
    .key_wr_i   (key_wr),
    .phone_wr_i (req_phone_q),
    .name_wr_i  (req_name_q),
    .key_rd_o   (key_rd),
    .phone_rd_o (phone_rd),
    .name_rd_o  (name_rd)
  );

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_mode_q  <= mode_e'(s_axis_tuser);
      req_key_q   <= s_axis_tdata[KEY_W-1:0];
      req_phone_q <= s_axis_tdata[KEY_W+PHONE_W-1:KEY_W];
      req_name_q  <= s_axis_tdata[KEY_W+PHONE_W+NAME_W-1:KEY_W+PHONE_W];
    end
  end

  // Track the read pipeline and record first match and last empty slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bad_q <= 1'b0;
      rvld_q    <= 1'b0;
      hit_q     <= 1'b0;
      empty_q   <= 1'b0;
    end else begin
      rvld_q <= ctl.key_rd;
      if (s_fire) begin
        req_bad_q <= (s_axis_tdata[KEY_W-1:0] == '0) ||
                     (s_axis_tuser != MODE_LOOKUP && s_axis_tuser != MODE_ADD &&
                      s_axis_tuser != MODE_REMOVE);
        hit_q     <= 1'b0;
        empty_q   <= 1'b0;
      end else if (rvld_q) begin
        if (key_rd == req_key_q && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (key_rd == '0) begin
          empty_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= idx_q[IW-1:0];
    if (rvld_q) begin
      if (key_rd == req_key_q && !hit_q) begin
        hit_idx_q <= ridx_q;
      end
      if (key_rd == '0) begin
        empty_idx_q <= ridx_q;
      end
    end
  end

  // Controller registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state, store access and result selection
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    ctl        = '0;
    addr       = idx_q[IW-1:0];
    key_wr     = '0;
    out_load   = 1'b0;
    res_status = STATUS_NOT_FOUND;
    res_touch  = 1'b0;
    res_slot   = hit_idx_q;
    use_rd     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        // sweep every key slot to empty
        ctl.key_wr = 1'b1;
        if (idx_q == NW'(TABLE_DEPTH - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + NW'(1);
        end
      end
      S_IDLE: begin
        if (s_fire) begin
          idx_d = '0;
          if ((s_axis_tdata[KEY_W-1:0] == '0) ||
              (s_axis_tuser != MODE_LOOKUP && s_axis_tuser != MODE_ADD &&
               s_axis_tuser != MODE_REMOVE)) begin
            state_d = S_DECIDE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue one key read per cycle, then drain the last one
        if (idx_q < n_slots) begin
          ctl.key_rd = 1'b1;
          idx_d      = idx_q + NW'(1);
        end else if (!rvld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (req_bad_q) begin
          out_load = out_free;
        end else begin
          case (req_mode_q)
            MODE_LOOKUP, MODE_REMOVE: begin
              if (hit_q) begin
                ctl.data_rd = 1'b1;
                addr        = hit_idx_q;
                state_d     = S_FETCH;
              end else begin
                out_load = out_free;
              end
            end
            MODE_ADD: begin
              if (hit_q) begin
                // update in place
                addr        = hit_idx_q;
                res_status  = STATUS_UPDATED;
                res_touch   = 1'b1;
                ctl.data_wr = out_free;
                out_load    = out_free;
              end else if ((NW'(cnt_q) >= n_slots) || !empty_q) begin
                res_status = STATUS_FULL;
                out_load   = out_free;
              end else begin
                // fill the highest empty slot
                addr        = empty_idx_q;
                key_wr      = req_key_q;
                res_status  = STATUS_ADDED;
                res_touch   = 1'b1;
                res_slot    = empty_idx_q;
                ctl.key_wr  = out_free;
                ctl.data_wr = out_free;
                out_load    = out_free;
                if (out_free) begin
                  cnt_d = cnt_q + CNT_W'(1);
                end
              end
            end
            default: begin
              out_load = out_free;
            end
          endcase
        end
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      S_FETCH: begin
        addr      = hit_idx_q;
        res_touch = 1'b1;
        use_rd    = 1'b1;
        out_load  = out_free;
        if (req_mode_q == MODE_LOOKUP) begin
          res_status = STATUS_FOUND;
        end else begin
          // empty the slot and uncount it
          res_status = STATUS_REMOVED;
          ctl.key_wr = out_free;
          if (out_free && cnt_q != '0) begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_status_q <= res_status;
      if (res_touch) begin
        m_slot_q  <= SLOT_W'(res_slot);
        m_key_q   <= req_key_q;
        m_phone_q <= use_rd ? phone_rd : req_phone_q;
        m_name_q  <= use_rd ? name_rd : req_name_q;
      end else begin
        m_slot_q  <= '0;
        m_key_q   <= '0;
        m_phone_q <= '0;
        m_name_q  <= '0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_name_q, m_phone_q, m_key_q, m_slot_q};

`ifndef SYNTH
  // The record count never exceeds the table depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(cnt_q) <= NW'(TABLE_DEPTH))
    else $error("record count above table depth");

  // Key reads stay within the configured slots
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.key_rd |-> (state_q == S_SCAN) && (idx_q < n_slots))
    else $error("key read outside scanned range");

  // An accepted request leaves the idle state
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> state_q != S_IDLE)
    else $error("request accepted without starting work");

  // The count moves only when a result is committed
  a_cnt_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(out_load))
    else $error("record count changed without a result");

  // No slot is touched by a write while a scan is running
  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ctl.key_wr && !ctl.data_wr)
    else $error("store write during scan");
`endif

endmodule

// ===== hdl/krt_store.sv =====
// ----------------------------------------------------------------------------
// krt_store: record store of the keyed record table
// One key memory and one phone/name memory sharing a single address, each
// with a registered read port and a write port.
// ----------------------------------------------------------------------------
module krt_store #(
  parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF,
  parameter int IW          = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk_i,
  input  krt_pkg::mem_ctl_t         ctl_i,
  input  logic [IW-1:0]             addr_i,
  input  logic [krt_pkg::KEY_W-1:0]   key_wr_i,
  input  logic [krt_pkg::PHONE_W-1:0] phone_wr_i,
  input  logic [krt_pkg::NAME_W-1:0]  name_wr_i,
  output logic [krt_pkg::KEY_W-1:0]   key_rd_o,
  output logic [krt_pkg::PHONE_W-1:0] phone_rd_o,
  output logic [krt_pkg::NAME_W-1:0]  name_rd_o
);
  import krt_pkg::*;

  logic [KEY_W-1:0]   key_mem   [TABLE_DEPTH];
  logic [PHONE_W-1:0] phone_mem [TABLE_DEPTH];
  logic [NAME_W-1:0]  name_mem  [TABLE_DEPTH];

  // Key memory: write or registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.key_wr) begin
      key_mem[addr_i] <= key_wr_i;
    end
    if (ctl_i.key_rd) begin
      key_rd_o <= key_mem[addr_i];
    end
  end

  // Phone and name memory: write or registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.data_wr) begin
      phone_mem[addr_i] <= phone_wr_i;
      name_mem[addr_i]  <= name_wr_i;
    end
    if (ctl_i.data_rd) begin
      phone_rd_o <= phone_mem[addr_i];
      name_rd_o  <= name_mem[addr_i];
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for keyed_record_table_core
// Sends lookup, add-or-update and remove requests over the request stream and
// checks every result against a local model of the record table. A directed
// table comes first: empty and full tables, extreme keys and data, zero key,
// the unused mode, and capacities of zero and above the table depth. Random
// phases follow under several capacity settings, with random gaps on the
// request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import krt_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int POOL_SIZE = 96;
  localparam int PHASE_ITEMS = 180;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [PHONE_W-1:0] PHONE_MAX = '1;
  localparam logic [NAME_W-1:0] NAME_MAX = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    key;
    logic [PHONE_W-1:0]  phone;
    logic [NAME_W-1:0]   name;
  } result_t;

  typedef struct {
    bit                  is_cfg;
    logic [CAP_W-1:0]    cap;
    logic [MODE_W-1:0]   mode;
    logic [KEY_W-1:0]    key;
    logic [PHONE_W-1:0]  phone;
    logic [NAME_W-1:0]   name;
    bit                  typed;
    result_t             want;
  } step_t;

  localparam result_t NO_RECORD  = '{STATUS_NOT_FOUND, '0, '0, '0, '0};
  localparam result_t TABLE_FULL = '{STATUS_FULL, '0, '0, '0, '0};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [MODE_W-1:0]     s_axis_tuser = '0;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  // Local copy of the table
  logic [KEY_W-1:0]   tbl_key   [DEPTH];
  logic [PHONE_W-1:0] tbl_phone [DEPTH];
  logic [NAME_W-1:0]  tbl_name  [DEPTH];
  int unsigned        rec_count = 0;
  logic [CAP_W-1:0]   cap_reg = CAP_RESET;

  result_t            pending_q [$];
  bit                 idle_on = 1'b1;
  int                 stall_left = 0;
  int                 quiet_cycles = 0;
  int                 fail_count = 0;
  int                 n_sent = 0;
  int                 n_cfg = 0;
  int                 status_hits [8];
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];

  keyed_record_table_core #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (tbl_key[i]) begin
      tbl_key[i] = '0;
      tbl_phone[i] = '0;
      tbl_name[i] = '0;
    end
    foreach (status_hits[i]) status_hits[i] = 0;
  end

  // Result of the record in one slot
  function automatic result_t slot_result(logic [STATUS_W-1:0] st, int idx);
    result_t r;
    r.status = st;
    r.slot = idx[SLOT_W-1:0];
    r.key = tbl_key[idx];
    r.phone = tbl_phone[idx];
    r.name = tbl_name[idx];
    return r;
  endfunction

  // Apply one request to the local table and return its result
  function automatic result_t predict_table(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                            logic [PHONE_W-1:0] phone,
                                            logic [NAME_W-1:0] name);
    int n;
    int hit;
    int hole;
    result_t r;
    r = NO_RECORD;
    n = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    if (key == '0 || mode == MODE_UNUSED) return r;
    hit = -1;
    hole = -1;
    for (int i = 0; i < n; i++) begin
      if (hit < 0 && tbl_key[i] == key) hit = i;
      if (tbl_key[i] == '0) hole = i;
    end
    case (mode)
      MODE_LOOKUP: begin
        if (hit >= 0) r = slot_result(STATUS_FOUND, hit);
      end
      MODE_ADD: begin
        if (hit >= 0) begin
          tbl_phone[hit] = phone;
          tbl_name[hit] = name;
          r = slot_result(STATUS_UPDATED, hit);
        end else if (rec_count >= n || hole < 0) begin
          r = TABLE_FULL;
        end else begin
          tbl_key[hole] = key;
          tbl_phone[hole] = phone;
          tbl_name[hole] = name;
          rec_count++;
          r = slot_result(STATUS_ADDED, hole);
        end
      end
      default: begin
        if (hit >= 0) begin
          r = slot_result(STATUS_REMOVED, hit);
          tbl_key[hit] = '0;
          if (rec_count > 0) rec_count--;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    if (k == '0) k = 1;
    return k;
  endfunction

  function automatic result_t known_result(logic [STATUS_W-1:0] st, int idx,
                                           logic [KEY_W-1:0] key, logic [PHONE_W-1:0] phone,
                                           logic [NAME_W-1:0] name);
    return '{st, idx[SLOT_W-1:0], key, phone, name};
  endfunction

  function automatic step_t request_row(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                        logic [PHONE_W-1:0] phone, logic [NAME_W-1:0] name,
                                        bit typed, result_t want);
    step_t s;
    s.is_cfg = 1'b0;
    s.cap = '0;
    s.mode = mode;
    s.key = key;
    s.phone = phone;
    s.name = name;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic step_t capacity_row(logic [CAP_W-1:0] cap);
    step_t s;
    s = request_row(MODE_LOOKUP, '0, '0, '0, 1'b0, NO_RECORD);
    s.is_cfg = 1'b1;
    s.cap = cap;
    return s;
  endfunction

  // Drive one request, hold it until accepted, then queue its expected result
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                              input logic [PHONE_W-1:0] phone,
                              input logic [NAME_W-1:0] name,
                              input bit typed, input result_t want);
    result_t guess;
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {2'b00, name, phone, key};
    do @(posedge clk_i); while (!s_axis_tready);
    guess = predict_table(mode, key, phone, name);
    pending_q.push_back(typed ? want : guess);
    n_sent++;
  endtask

  // Stop sending and hold until every pending result has arrived
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write with setup and access cycles, only while the block is idle
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_reg = value;
    n_cfg++;
  endtask

  task automatic check_field(input string field, input logic [NAME_W-1:0] want,
                             input logic [NAME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  // Check each result transaction and drive result-side stalls
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.slot = m_axis_tdata[5:0];
      got.key = m_axis_tdata[36:6];
      got.phone = m_axis_tdata[67:37];
      got.name = m_axis_tdata[131:68];
      if (pending_q.size() == 0) begin
        $error("result with no pending request: status %0d slot %0d", got.status, got.slot);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        check_field("status", NAME_W'(want.status), NAME_W'(got.status));
        check_field("slot", NAME_W'(want.slot), NAME_W'(got.slot));
        check_field("found_key", NAME_W'(want.key), NAME_W'(got.key));
        check_field("found_phone", NAME_W'(want.phone), NAME_W'(got.phone));
        check_field("found_name", want.name, got.name);
        check_field("tdata padding", '0, NAME_W'(m_axis_tdata[M_TDATA_W-1:132]));
        if (want.status < 8) status_hits[want.status]++;
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: end the run after too many cycles without a transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("keyed_record_table_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    step_t plan [$];
    logic [CAP_W-1:0] phase_caps [9];
    int span;
    int pick;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0] key;

    foreach (key_pool[i]) key_pool[i] = random_key();
    key_pool[0] = 1;
    key_pool[1] = KEY_MAX;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    plan.push_back(request_row(MODE_LOOKUP, 1, '0, '0, 1'b1, NO_RECORD));
    plan.push_back(request_row(MODE_ADD, 1, PHONE_MAX, NAME_MAX, 1'b1,
                               known_result(STATUS_ADDED, 63, 1, PHONE_MAX, NAME_MAX)));
    plan.push_back(request_row(MODE_ADD, KEY_MAX, '0, '0, 1'b1,
                               known_result(STATUS_ADDED, 62, KEY_MAX, '0, '0)));
    plan.push_back(request_row(MODE_LOOKUP, KEY_MAX, PHONE_MAX, NAME_MAX, 1'b1,
                               known_result(STATUS_FOUND, 62, KEY_MAX, '0, '0)));
    plan.push_back(request_row(MODE_ADD, 1, 31'h2AAA_AAAA, 64'h5555_5555_5555_5555, 1'b1,
                               known_result(STATUS_UPDATED, 63, 1, 31'h2AAA_AAAA,
                                            64'h5555_5555_5555_5555)));
    plan.push_back(request_row(MODE_LOOKUP, 1, '0, '0, 1'b0, NO_RECORD));
    // zero key and the unused mode change nothing
    plan.push_back(request_row(MODE_ADD, '0, PHONE_MAX, NAME_MAX, 1'b1, NO_RECORD));
    plan.push_back(request_row(MODE_LOOKUP, '0, '0, '0, 1'b1, NO_RECORD));
    plan.push_back(request_row(MODE_REMOVE, '0, '0, '0, 1'b1, NO_RECORD));
    plan.push_back(request_row(MODE_UNUSED, 1, PHONE_MAX, NAME_MAX, 1'b1, NO_RECORD));
    plan.push_back(request_row(MODE_REMOVE, 1, '0, '0, 1'b1,
                               known_result(STATUS_REMOVED, 63, 1, 31'h2AAA_AAAA,
                                            64'h5555_5555_5555_5555)));
    plan.push_back(request_row(MODE_REMOVE, 1, '0, '0, 1'b1, NO_RECORD));
    plan.push_back(request_row(MODE_ADD, 31'h5555_5555, 31'h0123_4567,
                               64'hA5A5_A5A5_A5A5_A5A5, 1'b0, NO_RECORD));
    // count already at capacity, and keys outside the scanned range
    plan.push_back(capacity_row(7'd2));
    plan.push_back(request_row(MODE_ADD, 7, PHONE_MAX, NAME_MAX, 1'b1, TABLE_FULL));
    plan.push_back(request_row(MODE_LOOKUP, KEY_MAX, '0, '0, 1'b1, NO_RECORD));
    plan.push_back(request_row(MODE_REMOVE, 31'h5555_5555, '0, '0, 1'b1, NO_RECORD));
    // capacity zero scans nothing
    plan.push_back(capacity_row(7'd0));
    plan.push_back(request_row(MODE_ADD, 9, '0, '0, 1'b1, TABLE_FULL));
    plan.push_back(request_row(MODE_LOOKUP, 9, '0, '0, 1'b1, NO_RECORD));
    // capacity above depth is clipped to the depth
    plan.push_back(capacity_row(7'd100));
    plan.push_back(request_row(MODE_LOOKUP, KEY_MAX, '0, '0, 1'b0, NO_RECORD));
    plan.push_back(capacity_row(7'd127));
    plan.push_back(request_row(MODE_ADD, 3, 31'h1357_9BDF, 64'h0F0F_F0F0_3C3C_C3C3,
                               1'b0, NO_RECORD));
    plan.push_back(request_row(MODE_REMOVE, 31'h5555_5555, '0, '0, 1'b0, NO_RECORD));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_capacity(plan[i].cap);
      else send_request(plan[i].mode, plan[i].key, plan[i].phone, plan[i].name,
                        plan[i].typed, plan[i].want);
    end

    // Random phases, each under its own capacity
    phase_caps[0] = 7'd1;
    phase_caps[1] = 7'd64;
    phase_caps[2] = 7'($urandom_range(2, 8));
    phase_caps[3] = 7'd0;
    phase_caps[4] = 7'($urandom_range(9, 63));
    phase_caps[5] = 7'd127;
    phase_caps[6] = 7'd100;
    phase_caps[7] = 7'd2;
    phase_caps[8] = 7'd64;

    foreach (phase_caps[p]) begin
      // empty the whole table before every other phase
      if (p % 2 == 0) begin
        set_capacity(7'(DEPTH));
        for (int s = 0; s < DEPTH; s++) begin
          if (tbl_key[s] != '0)
            send_request(MODE_REMOVE, tbl_key[s], '0, '0, 1'b0, NO_RECORD);
        end
      end
      set_capacity(phase_caps[p]);
      idle_on = (p != 2) && (p != 8);
      span = int'(phase_caps[p]) + 8;
      if (span > POOL_SIZE) span = POOL_SIZE;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, span - 1)]
                                           : random_key();
        if (pick < 4) begin
          mode = MODE_UNUSED;
        end else if (pick < 8) begin
          mode = MODE_W'($urandom_range(0, 2));
          key = '0;
        end else if (pick < 52) begin
          mode = MODE_ADD;
        end else if (pick < 76) begin
          mode = MODE_LOOKUP;
        end else begin
          mode = MODE_REMOVE;
        end
        send_request(mode, key, PHONE_W'($urandom), {$urandom, $urandom}, 1'b0, NO_RECORD);
      end
    end

    // Drain and let the block settle
    wait_results();
    repeat (100) @(posedge clk_i);
    fail_count += pending_q.size();

    $display("Covered %0d requests under %0d capacity writes, including zero and above depth",
             n_sent, n_cfg);
    $display("Results: %0d found, %0d not found, %0d added, %0d updated, %0d full, %0d removed",
             status_hits[STATUS_FOUND], status_hits[STATUS_NOT_FOUND],
             status_hits[STATUS_ADDED], status_hits[STATUS_UPDATED],
             status_hits[STATUS_FULL], status_hits[STATUS_REMOVED]);
    if (fail_count == 0) begin
      $display("keyed_record_table_core test passed");
    end else begin
      $display("keyed_record_table_core test failed");
    end
    $finish;
  end

endmodule
